// File: rtl/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DAT_W    = 32;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_FWD     = 3'd2,
    REQ_REV     = 3'd3,
    REQ_COUNT   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROTL,
    OP_ROTR
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FWD,
    S_REV
  } state_t;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [DAT_W-1:0] value;
    logic [CNT_W-1:0]        position;
  } in_word_t;

  typedef struct packed {
    logic signed [DAT_W-1:0] value_res;
    logic [CNT_W-1:0]        count;
    logic [1:0]              status;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        idx;
    logic signed [DAT_W-1:0] value;
  } chain_ctl_t;

endpackage

// File: rtl/ple_cell.sv
module ple_cell import ple_pkg::*; (
  input  logic                    clk,
  input  chain_ctl_t              ctl,
  input  logic [IDX_W-1:0]        slot,
  input  logic signed [DAT_W-1:0] left,
  input  logic signed [DAT_W-1:0] right,
  output logic signed [DAT_W-1:0] q
);

  logic signed [DAT_W-1:0] q_r;
  logic signed [DAT_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.op)
      OP_INS: begin
        if (slot > ctl.idx) begin
          q_nxt = left;
        end else if (slot == ctl.idx) begin
          q_nxt = ctl.value;
        end
      end
      OP_DEL: begin
        if (slot >= ctl.idx) begin
          q_nxt = right;
        end
      end
      OP_ROTL: q_nxt = right;
      OP_ROTR: q_nxt = left;
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// File: rtl/ple_chain.sv
module ple_chain import ple_pkg::*; (
  input  logic                    clk,
  input  chain_ctl_t              ctl,
  output logic signed [DAT_W-1:0] head,
  output logic signed [DAT_W-1:0] tail
);

  logic signed [DAT_W-1:0] v [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DAT_W-1:0] left;
    logic signed [DAT_W-1:0] right;

    if (g == 0) begin : g_first
      assign left = v[CAPACITY-1];
    end else begin : g_mid_l
      assign left = v[g-1];
    end

    if (g == CAPACITY-1) begin : g_last
      assign right = v[0];
    end else begin : g_mid_r
      assign right = v[g+1];
    end

    ple_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .slot  (IDX_W'(g)),
      .left  (left),
      .right (right),
      .q     (v[g])
    );
  end

  assign head = v[0];
  assign tail = v[CAPACITY-1];

endmodule

// File: rtl/positional_list_engine.sv
// Channel | Direction | Word       | Handshake
// in_     | input     | in_word_t  | in_valid / in_ready
// out_    | output    | out_word_t | out_valid / out_ready
//
// Insert, delete and count need no display pass: the cell chain shifts the whole list at once.
// A display rotates the full ring of CAPACITY cells, one cell a cycle unless a stalled
// output holds it; forward emits during the first count rotations, reverse during the
// last count. An empty display returns only an empty-status word.
// Synchronous active-low reset clears the entry count; cell contents are not reset.
// A stalled output holds the ring only when the next rotation is due to emit a word.
module positional_list_engine import ple_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r;
  out_word_t        out_word_r;
  logic             out_load;
  out_word_t        out_word_nxt;
  chain_ctl_t       ctl;
  logic signed [DAT_W-1:0] head, tail;

  logic             out_free;
  logic             acc;
  logic             emit;
  logic             step;
  logic             k_end;
  logic [CNT_W:0]   pos_x, cnt_x, k_x;
  logic [CNT_W-1:0] ins_idx, del_idx;
  logic             ins_ok, del_ok;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;

  assign pos_x = {1'b0, in_word.position};
  assign cnt_x = {1'b0, cnt_r};
  assign k_x   = (CNT_W+1)'(k_r);
  assign k_end = (k_r == IDX_W'(CAPACITY-1));

  always_comb begin
    ins_ok  = 1'b1;
    ins_idx = '0;
    if (cnt_r == '0 || in_word.position == CNT_W'(1)) begin
      ins_idx = '0;
    end else if (in_word.position == '0) begin
      ins_idx = CNT_W'(1);
    end else if (pos_x <= cnt_x + (CNT_W+1)'(1)) begin
      ins_idx = in_word.position - CNT_W'(1);
    end else begin
      ins_ok = 1'b0;
    end
    del_idx = (in_word.position == '0) ? CNT_W'(1) : in_word.position - CNT_W'(1);
    del_ok  = del_idx < cnt_r;
  end

  always_comb begin
    priority case (state_r)
      S_FWD:   emit = k_x < cnt_x;
      S_REV:   emit = (k_x + cnt_x) >= (CNT_W+1)'(CAPACITY);
      default: emit = 1'b0;
    endcase
    step = !emit || out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && cnt_r != '0) begin
          if (in_word.req_type == REQ_FWD) begin
            state_nxt = S_FWD;
          end else if (in_word.req_type == REQ_REV) begin
            state_nxt = S_REV;
          end
        end
      end
      S_FWD, S_REV: begin
        if (step && k_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '{op: OP_HOLD, idx: '0, value: in_word.value};
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    out_load     = 1'b0;
    out_word_nxt = '{value_res: '0, count: cnt_r, status: ST_OK, last: 1'b1};
    unique case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        if (acc) begin
          out_load = 1'b1;
          priority if (in_word.req_type == REQ_INSERT) begin
            if (cnt_r >= CNT_W'(CAPACITY)) begin
              out_word_nxt.status = ST_FULL;
            end else if (!ins_ok) begin
              out_word_nxt.status = ST_INVALID;
            end else begin
              ctl.op               = OP_INS;
              ctl.idx              = ins_idx[IDX_W-1:0];
              cnt_nxt              = cnt_r + CNT_W'(1);
              out_word_nxt.count   = cnt_nxt;
            end
          end else if (in_word.req_type == REQ_DELETE) begin
            if (!del_ok) begin
              out_word_nxt.status = ST_INVALID;
            end else begin
              ctl.op             = OP_DEL;
              ctl.idx            = del_idx[IDX_W-1:0];
              cnt_nxt            = cnt_r - CNT_W'(1);
              out_word_nxt.count = cnt_nxt;
            end
          end else if (in_word.req_type == REQ_FWD || in_word.req_type == REQ_REV) begin
            if (cnt_r == '0) begin
              out_word_nxt.status = ST_EMPTY;
            end else begin
              out_load = 1'b0;
            end
          end else if (in_word.req_type == REQ_COUNT) begin
            out_load = 1'b1;
          end else begin
            out_load = 1'b0;
          end
        end
      end
      S_FWD, S_REV: begin
        if (step) begin
          ctl.op   = (state_r == S_FWD) ? OP_ROTL : OP_ROTR;
          k_nxt    = k_r + IDX_W'(1);
          out_load = emit;
          if (state_r == S_FWD) begin
            out_word_nxt.value_res = head;
            out_word_nxt.last      = (k_x + (CNT_W+1)'(1)) == cnt_x;
          end else begin
            out_word_nxt.value_res = tail;
            out_word_nxt.last      = k_end;
          end
        end
      end
      default: begin
        k_nxt = '0;
      end
    endcase
  end

  ple_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head),
    .tail (tail)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      if (out_free) begin
        out_valid_r <= out_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/ple_checker.sv
module ple_checker import ple_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_FULL |-> out_word.count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_EMPTY |->
      out_word.count == '0 && out_word.last && out_word.value_res == '0)
    else $error("malformed empty-list word");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// File: tb/positional_list_engine_test.sv
`timescale 1ns / 1ps

module positional_list_engine_test;
  import ple_pkg::*;

  localparam int REQ_CODES    = 8;
  localparam int STALL_AT     = 40;
  localparam int STALL_CYCLES = 400;
  localparam int FILL_CAP     = 130;
  localparam int DRAIN_ITEMS  = 30;
  localparam int CYCLE_LIMIT  = 400000;

  class list_tracker;
    logic signed [DAT_W-1:0] shadow[$];
    out_word_t               expected_words[$];
    int unsigned             errors;
    int unsigned             requests_noted;
    int unsigned             words_checked;
    int unsigned             peak_held;
    int unsigned             status_hits[4];

    function int held();
      return shadow.size();
    endfunction

    function void expect_word(logic signed [DAT_W-1:0] v, status_t st, logic lst);
      out_word_t w;
      w.value_res = v;
      w.count     = CNT_W'(shadow.size());
      w.status    = st;
      w.last      = lst;
      expected_words.push_back(w);
      status_hits[st]++;
    endfunction

    function void note_request(in_word_t w);
      status_t st;
      int      n;
      int      slot;
      n = shadow.size();
      st = ST_OK;
      case (w.req_type)
        REQ_INSERT: begin
          if (n >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            if (n == 0 || w.position == 1) slot = 0;
            else if (w.position == 0) slot = 1;
            else if (int'(w.position) <= n + 1) slot = int'(w.position) - 1;
            else st = ST_INVALID;
            if (st == ST_OK) shadow.insert(slot, w.value);
          end
          expect_word('0, st, 1'b1);
        end
        REQ_DELETE: begin
          slot = (w.position == 0) ? 1 : int'(w.position) - 1;
          if (slot < n) shadow.delete(slot);
          else st = ST_INVALID;
          expect_word('0, st, 1'b1);
        end
        REQ_FWD, REQ_REV: begin
          if (n == 0) begin
            expect_word('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) begin
              slot = (w.req_type == REQ_FWD) ? i : n - 1 - i;
              expect_word(shadow[slot], ST_OK, i == n - 1);
            end
          end
        end
        REQ_COUNT: expect_word('0, ST_OK, 1'b1);
        default: ;
      endcase
      requests_noted++;
      if (shadow.size() > peak_held) peak_held = shadow.size();
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h, expected none", $time, got);
        return;
      end
      want = expected_words.pop_front();
      if (got.value_res !== want.value_res) begin
        errors++;
        $display("%0t: value_res expected %0d, actual %0d", $time, want.value_res,
                 got.value_res);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: count expected %0d, actual %0d", $time, want.count, got.count);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0d, actual %0d", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  bit        pacing;
  int unsigned cycles = 0;

  list_tracker tracker = new();

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_request(in_word);
      if (out_valid && out_ready) tracker.check_word(out_word);
    end
  end

  function automatic in_word_t make_word(logic [2:0] code, logic signed [DAT_W-1:0] v,
                                         logic [CNT_W-1:0] p);
    in_word_t w;
    w.req_type = code;
    w.value    = v;
    w.position = p;
    return w;
  endfunction

  function automatic in_word_t random_request(int ins_pct, int del_pct);
    in_word_t w;
    int       roll;
    int       n;
    n = tracker.held();
    roll = $urandom_range(0, 99);
    w.value = $urandom();
    case ($urandom_range(0, 9))
      0: w.position = CNT_W'($urandom_range(0, 127));
      1: w.position = '0;
      default: w.position = CNT_W'($urandom_range(1, n + 1));
    endcase
    if (roll < ins_pct) begin
      w.req_type = REQ_INSERT;
    end else if (roll < ins_pct + del_pct) begin
      w.req_type = REQ_DELETE;
    end else begin
      case ($urandom_range(0, 6))
        0, 1: w.req_type = REQ_FWD;
        2, 3: w.req_type = REQ_REV;
        4, 5: w.req_type = REQ_COUNT;
        default: w.req_type = 3'($urandom_range(int'(REQ_COUNT) + 1, REQ_CODES - 1));
      endcase
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = pacing ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sink_results();
    int unsigned gap;
    bit          stalled;
    stalled = 1'b0;
    forever begin
      if (!stalled && tracker.requests_noted >= STALL_AT) begin
        stalled = 1'b1;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      gap = pacing ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  endtask

  initial begin
    in_word_t w;
    int       sent;
    int       full_tries;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_ready = 1'b0;
    pacing    = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    fork
      sink_results();
    join_none

    send_word(make_word(REQ_FWD, 0, 7'd0));
    send_word(make_word(REQ_REV, 0, 7'd0));
    send_word(make_word(REQ_COUNT, 0, 7'd0));
    send_word(make_word(REQ_DELETE, 0, 7'd1));
    send_word(make_word(REQ_DELETE, 0, 7'd0));
    send_word(make_word(REQ_INSERT, 32'sh7fffffff, 7'd127));
    send_word(make_word(REQ_DELETE, 0, 7'd0));
    send_word(make_word(REQ_INSERT, 32'sh80000000, 7'd1));
    send_word(make_word(REQ_INSERT, -32'sd1, 7'd0));
    send_word(make_word(REQ_INSERT, 0, 7'd4));
    send_word(make_word(REQ_INSERT, 32'sh2aaaaaaa, 7'd6));
    send_word(make_word(REQ_INSERT, 32'sh55555555, 7'd5));
    send_word(make_word(REQ_FWD, 0, 7'd0));
    send_word(make_word(REQ_REV, 0, 7'd0));
    send_word(make_word(REQ_DELETE, 0, 7'd5));
    send_word(make_word(REQ_DELETE, 0, 7'd0));
    send_word(make_word(REQ_DELETE, 0, 7'd1));
    send_word(make_word(REQ_DELETE, 0, 7'd127));
    for (int c = int'(REQ_COUNT) + 1; c < REQ_CODES; c++)
      send_word(make_word(3'(c), $urandom(), CNT_W'($urandom_range(0, 127))));
    send_word(make_word(REQ_COUNT, 0, 7'd0));
    send_word(make_word(REQ_REV, 0, 7'd0));

    sent = 0;
    full_tries = 0;
    while ((tracker.held() < CAPACITY || full_tries < 4) && sent < FILL_CAP) begin
      if (sent % 20 == 0) pacing = ($urandom_range(0, 3) != 0);
      w = random_request(88, 4);
      if (w.req_type == REQ_INSERT && tracker.held() >= CAPACITY) full_tries++;
      send_word(w);
      if (w.req_type <= REQ_COUNT) sent++;
    end

    sent = 0;
    while (sent < DRAIN_ITEMS) begin
      if (sent % 20 == 0) pacing = ($urandom_range(0, 3) != 0);
      w = random_request(25, 45);
      send_word(w);
      if (w.req_type <= REQ_COUNT) sent++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY) @(posedge clk);

    $display("Run covered %0d requests and %0d result words, peak occupancy %0d of %0d.",
             tracker.requests_noted, tracker.words_checked, tracker.peak_held, CAPACITY);
    $display("Status words: ok %0d, invalid %0d, full %0d, empty %0d.",
             tracker.status_hits[ST_OK], tracker.status_hits[ST_INVALID],
             tracker.status_hits[ST_FULL], tracker.status_hits[ST_EMPTY]);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
